// File: sv/twr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twr_pkg
// Shared types, command codes and BCD helpers for the three-wire bus master.
// ----------------------------------------------------------------------------
package twr_pkg;

    typedef logic [1:0] cmd_code_t;
    typedef logic [7:0] byte_t;
    typedef logic [3:0] count_t;
    typedef logic [2:0] slot_t;

    // Request command codes
    localparam cmd_code_t CMD_TICK  = 2'd0;
    localparam cmd_code_t CMD_LOAD  = 2'd1;
    localparam cmd_code_t CMD_START = 2'd2;

    // One result as it leaves the core
    typedef struct packed {
        logic  sclk;
        logic  ce;
        logic  io_out;
        logic  io_drive;
        logic  busy_res;
        logic  rd_valid;
        byte_t rd_byte;
        slot_t rd_index;
        logic  rd_last;
    } result_t;

    // Binary to BCD; tens come from a multiply by the reciprocal of ten,
    // exact over all 8-bit values. Tens above nine wrap into the high nibble.
    function automatic byte_t to_bcd(input byte_t v);
        logic [15:0] prod;
        logic [7:0]  tens;
        logic [7:0]  ones;
        begin
            prod = 16'(v) * 16'd205;
            tens = prod[15:11] == 5'd0 ? 8'd0 : 8'(prod[15:11]);
            ones = v - 8'(tens * 8'd10);
            return {tens[3:0], ones[3:0]};
        end
    endfunction

    // BCD to binary, wrapping to 8 bits
    function automatic byte_t from_bcd(input byte_t v);
        logic [7:0] hi;
        begin
            hi = 8'(v[7:4]);
            return 8'(hi * 8'd10) + 8'(v[3:0]);
        end
    endfunction

endpackage
`default_nettype wire

// File: sv/twr_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twr_req_if
// Request channel of the three-wire bus master: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface twr_req_if;
    import twr_pkg::*;

    logic      valid;
    logic      ready;
    cmd_code_t command;
    byte_t     cmd_byte;
    count_t    byte_count;
    slot_t     buf_index;
    byte_t     buf_value;
    logic      bcd_mode;
    logic      io_in;

    modport source (
        output valid, command, cmd_byte, byte_count, buf_index, buf_value,
               bcd_mode, io_in,
        input  ready
    );

    modport sink (
        input  valid, command, cmd_byte, byte_count, buf_index, buf_value,
               bcd_mode, io_in,
        output ready
    );
endinterface
`default_nettype wire

// File: sv/twr_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twr_res_if
// Result channel of the three-wire bus master: pin levels and read bytes.
// ----------------------------------------------------------------------------
interface twr_res_if;
    import twr_pkg::*;

    logic  valid;
    logic  ready;
    logic  sclk;
    logic  ce;
    logic  io_out;
    logic  io_drive;
    logic  busy_res;
    logic  rd_valid;
    byte_t rd_byte;
    slot_t rd_index;
    logic  rd_last;

    modport source (
        output valid, sclk, ce, io_out, io_drive, busy_res, rd_valid, rd_byte,
               rd_index, rd_last,
        input  ready
    );

    modport sink (
        input  valid, sclk, ce, io_out, io_drive, busy_res, rd_valid, rd_byte,
               rd_index, rd_last,
        output ready
    );
endinterface
`default_nettype wire

// File: sv/three_wire_rtc_bus_master_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_wire_rtc_bus_master_core
// Master for a three-wire clock-chip bus (CE, SCLK, one bidirectional line).
// ----------------------------------------------------------------------------
// Every request is one step of the bit-timing machine: a tick, a write-buffer
// load or a transaction start. The core takes one request per clock while
// ready is high and returns exactly one result per request, in order, through
// a two-entry output buffer that takes one more request while the result side
// stalls; ready drops only when both entries are full.
// The whole step (divider, bit and byte counters, shift register, pins, BCD
// conversion) is one pass of logic between the request handshake and the
// output buffer. On the bus, each SCLK half period lasts max(half_period, 1)
// tick requests; a transaction takes 16 half periods per byte, command byte
// included. Commands go out LSB first, data change while SCLK is low and read
// data are sampled on the tick that raises SCLK. half_period sits at byte
// address 0 of the APB port and should only be written while no transaction
// runs.
// ----------------------------------------------------------------------------
module three_wire_rtc_bus_master_core #(
    parameter int BURST_BYTES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    twr_req_if.sink          req,
    twr_res_if.source        resp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import twr_pkg::*;

    localparam int BUF_AW = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;
    localparam int IDX_W  = (BUF_AW > 4) ? BUF_AW : 4;

    // Phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_CMD_LO = 3'd1;
    localparam logic [2:0] PH_CMD_HI = 3'd2;
    localparam logic [2:0] PH_WR_LO  = 3'd3;
    localparam logic [2:0] PH_WR_HI  = 3'd4;
    localparam logic [2:0] PH_RD_LO  = 3'd5;
    localparam logic [2:0] PH_RD_HI  = 3'd6;

    localparam logic HALF_PERIOD_ADDR = 1'b0;

    // Configuration and transfer state
    logic [7:0] half_period_reg;
    byte_t      wbuf_reg [BURST_BYTES];
    byte_t      shift_reg,  shift_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;
    count_t     byte_cnt_reg, byte_cnt_next;
    logic [2:0] phase_reg, phase_next;
    logic [7:0] div_cnt_reg, div_cnt_next;
    logic       setup_rd_reg, setup_rd_next;
    count_t     setup_cnt_reg, setup_cnt_next;
    logic       setup_bcd_reg, setup_bcd_next;
    logic       sclk_reg, sclk_next;
    logic       ce_reg, ce_next;
    logic       io_reg, io_next;

    // Output buffer
    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg,  out_data_next;
    logic       skid_valid_reg, skid_valid_next;
    result_t    skid_data_reg,  skid_data_next;

    logic       req_acc;
    logic       cfg_wr;
    result_t    res;
    logic       buf_wr;
    logic [BUF_AW-1:0] buf_waddr;

    assign req.ready = !skid_valid_reg;
    assign req_acc   = req.valid && req.ready;

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == HALF_PERIOD_ADDR);
    assign prdata = (paddr[2] == HALF_PERIOD_ADDR) ? {24'd0, half_period_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            half_period_reg <= 8'd144;
        end
        else if (cfg_wr)
        begin
            half_period_reg <= pwdata[7:0];
        end
    end

    // Write buffer; slots beyond the buffer are dropped
    always_comb
    begin
        logic [IDX_W-1:0] widx;
        widx      = IDX_W'(req.buf_index);
        buf_waddr = widx[BUF_AW-1:0];
        buf_wr    = req_acc && (req.command == CMD_LOAD)
                    && (int'(req.buf_index) < BURST_BYTES);
    end

    always_ff @(posedge clk)
    begin
        if (buf_wr)
        begin
            wbuf_reg[buf_waddr] <= req.buf_value;
        end
    end

    // One step of the bit-timing machine
    always_comb
    begin
        logic [IDX_W-1:0] ridx;
        logic [8:0]       div_inc;
        logic [8:0]       half_eff;
        byte_t            wbyte;
        count_t           cnt;
        logic             driving;
        logic             load_wr;
        count_t           load_idx;

        shift_next     = shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        phase_next     = phase_reg;
        div_cnt_next   = div_cnt_reg;
        setup_rd_next  = setup_rd_reg;
        setup_cnt_next = setup_cnt_reg;
        setup_bcd_next = setup_bcd_reg;
        sclk_next      = sclk_reg;
        ce_next        = ce_reg;
        io_next        = io_reg;
        res            = '0;
        load_wr        = 1'b0;
        load_idx       = byte_cnt_reg;
        cnt            = req.byte_count;

        half_eff = (half_period_reg == 8'd0) ? 9'd1 : 9'(half_period_reg);
        div_inc  = 9'(div_cnt_reg) + 9'd1;

        if (req.command == CMD_START && phase_reg == PH_IDLE)
        begin
            // Latch the transfer set-up and raise CE
            if (cnt == 4'd0)
            begin
                cnt = 4'd1;
            end
            if (int'(cnt) > BURST_BYTES)
            begin
                cnt = 4'(BURST_BYTES);
            end
            setup_rd_next  = req.cmd_byte[0];
            setup_cnt_next = cnt;
            setup_bcd_next = req.bcd_mode;
            shift_next     = req.cmd_byte;
            bit_cnt_next   = 3'd0;
            byte_cnt_next  = 4'd0;
            div_cnt_next   = 8'd0;
            phase_next     = PH_CMD_LO;
            sclk_next      = 1'b0;
            ce_next        = 1'b1;
            io_next        = req.cmd_byte[0];
        end
        else if (req.command == CMD_TICK && phase_reg != PH_IDLE)
        begin
            if (div_inc < half_eff)
            begin
                div_cnt_next = div_inc[7:0];
            end
            else
            begin
                div_cnt_next = 8'd0;
                unique case (phase_reg)
                    PH_CMD_LO, PH_WR_LO, PH_RD_LO:
                    begin
                        // Rising SCLK; sample the line on reads
                        if (phase_reg == PH_RD_LO)
                        begin
                            shift_next = {req.io_in, shift_reg[7:1]};
                        end
                        sclk_next  = 1'b1;
                        phase_next = phase_reg + 3'd1;
                    end
                    PH_CMD_HI, PH_WR_HI, PH_RD_HI:
                    begin
                        // Falling SCLK; advance to the next bit or byte
                        sclk_next    = 1'b0;
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        if (phase_reg != PH_RD_HI)
                        begin
                            shift_next = {1'b0, shift_reg[7:1]};
                            io_next    = shift_reg[1];
                        end
                        if (bit_cnt_next != 3'd0)
                        begin
                            phase_next = phase_reg - 3'd1;
                        end
                        else if (phase_reg == PH_CMD_HI)
                        begin
                            if (setup_rd_reg)
                            begin
                                shift_next = 8'd0;
                                io_next    = 1'b0;
                                phase_next = PH_RD_LO;
                            end
                            else
                            begin
                                load_wr    = 1'b1;
                                load_idx   = byte_cnt_reg;
                                phase_next = PH_WR_LO;
                            end
                        end
                        else if (phase_reg == PH_WR_HI)
                        begin
                            byte_cnt_next = byte_cnt_reg + 4'd1;
                            if (byte_cnt_next >= setup_cnt_reg)
                            begin
                                phase_next   = PH_IDLE;
                                sclk_next    = 1'b0;
                                ce_next      = 1'b0;
                                io_next      = 1'b0;
                                div_cnt_next = 8'd0;
                            end
                            else
                            begin
                                load_wr    = 1'b1;
                                load_idx   = byte_cnt_next;
                                phase_next = PH_WR_LO;
                            end
                        end
                        else
                        begin
                            // Report the completed read byte
                            res.rd_valid  = 1'b1;
                            res.rd_byte   = setup_bcd_reg ? from_bcd(shift_reg) : shift_reg;
                            res.rd_index  = byte_cnt_reg[2:0];
                            byte_cnt_next = byte_cnt_reg + 4'd1;
                            if (byte_cnt_next >= setup_cnt_reg)
                            begin
                                res.rd_last  = 1'b1;
                                phase_next   = PH_IDLE;
                                sclk_next    = 1'b0;
                                ce_next      = 1'b0;
                                io_next      = 1'b0;
                                div_cnt_next = 8'd0;
                            end
                            else
                            begin
                                shift_next = 8'd0;
                                phase_next = PH_RD_LO;
                            end
                        end
                    end
                    default:
                    begin
                        // Unused phase code: drop back to idle
                        phase_next   = PH_IDLE;
                        sclk_next    = 1'b0;
                        ce_next      = 1'b0;
                        io_next      = 1'b0;
                        div_cnt_next = 8'd0;
                    end
                endcase
            end
        end

        // Fetch the next write byte from the buffer
        ridx  = IDX_W'(load_idx);
        wbyte = (int'(load_idx) < BURST_BYTES) ? wbuf_reg[ridx[BUF_AW-1:0]] : 8'd0;
        if (setup_bcd_next)
        begin
            wbyte = to_bcd(wbyte);
        end
        if (load_wr)
        begin
            shift_next = wbyte;
            io_next    = wbyte[0];
        end

        // Pin and status view after the step
        driving      = (phase_next == PH_CMD_LO) || (phase_next == PH_CMD_HI)
                       || (phase_next == PH_WR_LO) || (phase_next == PH_WR_HI);
        res.sclk     = sclk_next;
        res.ce       = ce_next;
        res.io_out   = driving && io_next;
        res.io_drive = driving;
        res.busy_res = phase_next != PH_IDLE;
    end

    // Transfer state registers, advanced only by an accepted request
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            shift_reg     <= 8'd0;
            bit_cnt_reg   <= 3'd0;
            byte_cnt_reg  <= 4'd0;
            phase_reg     <= PH_IDLE;
            div_cnt_reg   <= 8'd0;
            setup_rd_reg  <= 1'b0;
            setup_cnt_reg <= 4'd0;
            setup_bcd_reg <= 1'b0;
            sclk_reg      <= 1'b0;
            ce_reg        <= 1'b0;
            io_reg        <= 1'b0;
        end
        else if (req_acc)
        begin
            shift_reg     <= shift_next;
            bit_cnt_reg   <= bit_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
            phase_reg     <= phase_next;
            div_cnt_reg   <= div_cnt_next;
            setup_rd_reg  <= setup_rd_next;
            setup_cnt_reg <= setup_cnt_next;
            setup_bcd_reg <= setup_bcd_next;
            sclk_reg      <= sclk_next;
            ce_reg        <= ce_next;
            io_reg        <= io_next;
        end
    end

    // Two-entry output buffer: output register plus skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || resp.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = req_acc;
                out_data_next  = res;
            end
        end
        else if (req_acc)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign resp.valid    = out_valid_reg;
    assign resp.sclk     = out_data_reg.sclk;
    assign resp.ce       = out_data_reg.ce;
    assign resp.io_out   = out_data_reg.io_out;
    assign resp.io_drive = out_data_reg.io_drive;
    assign resp.busy_res = out_data_reg.busy_res;
    assign resp.rd_valid = out_data_reg.rd_valid;
    assign resp.rd_byte  = out_data_reg.rd_byte;
    assign resp.rd_index = out_data_reg.rd_index;
    assign resp.rd_last  = out_data_reg.rd_last;

    // Skid entry never holds a result ahead of an empty output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // Skid entry fills only while the output is stalled
    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !resp.ready))
        else $error("skid entry filled without a stalled output");

    // CE is high exactly while a transaction runs
    a_ce_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ce_reg == (phase_reg != PH_IDLE))
        else $error("CE out of step with the transfer phase");

    // SCLK rises only out of a low phase
    a_sclk_rise_from_low: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sclk_reg) |-> ($past(phase_reg) == PH_CMD_LO
                             || $past(phase_reg) == PH_WR_LO
                             || $past(phase_reg) == PH_RD_LO))
        else $error("SCLK rose outside a low phase");

endmodule
`default_nettype wire
